// File: sv/ppte_pkg.sv
// shared types, constants and codes of the paired page table engine
`default_nettype none
package ppte_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  // address layout
  localparam int TAG_LSB    = 13;
  localparam int PAGE_SHIFT = 12;
  localparam int TAG_W      = 32 - TAG_LSB;
  localparam int FRAME_W    = 32 - PAGE_SHIFT;
  localparam int ASID_W     = 8;

  // operation codes
  localparam logic [1:0] FUNC_MAP    = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_SET    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REMAP    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_UNMAPPED = 2'd3;

  // one table entry, both halves (bit 0 even, bit 1 odd)
  typedef struct packed {
    logic [ASID_W-1:0]  space_id;
    logic [TAG_W-1:0]   tag;
    logic [FRAME_W-1:0] even_frame;
    logic [FRAME_W-1:0] odd_frame;
    logic [1:0]         valid;
    logic [1:0]         writable;
  } entry_t;

endpackage
`default_nettype wire

// File: sv/ppte_table_ram.sv
// entry memory of the paired page table: one write port, one registered read port
`default_nettype none
module ppte_table_ram #(
  parameter int DEPTH  = ppte_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire ppte_pkg::entry_t  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output ppte_pkg::entry_t       rd_data
);

  ppte_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/paired_page_table_engine_unit.sv
// top level of the paired page table engine: request sequencer, table scan and result register
// sequence: accept, one read per entry, the last compare, then the update; an early match
//   ends the scan sooner, and an empty table or unused func skips the scan
// throughput: one request at a time; the linear scan through the entry memory sets the rate,
//   and the finish cycle waits while a stalled result still holds the output register
// reset: used count, address space id, sequencer and output valid are cleared; the entry
//   memory is not cleared, only entries below the used count are ever read
`default_nettype none
module paired_page_table_engine_unit #(
  parameter int TABLE_ENTRIES = ppte_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] virt_addr,
  input  wire logic [31:0] phys_addr,
  input  wire logic        write_enable,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      page_base,
  output logic [6:0]       entries_used
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // sequencer codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;

  // configuration register, always ready
  logic [ppte_pkg::ASID_W-1:0] asid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      asid <= '0;
    end else if (cfg_valid && cfg_ready) begin
      asid <= cfg_data;
    end
  end

  // latched request
  logic [1:0]                   req_func;
  logic [ppte_pkg::TAG_W-1:0]   req_tag;
  logic                         req_half;
  logic [ppte_pkg::FRAME_W-1:0] req_frame;
  logic                         req_we;

  // scan bookkeeping
  logic [CNT_W-1:0] used_count;   // entries filled from slot 0 upward
  logic [CNT_W-1:0] issue;        // next entry to read
  logic             pend;         // read data in flight for cmp_idx
  logic [IDX_W-1:0] cmp_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  ppte_pkg::entry_t hit_entry;

  // memory ports
  logic             rd_en;
  ppte_pkg::entry_t rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ppte_pkg::entry_t wr_data;

  ppte_table_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // keep issuing reads while entries remain
  assign rd_en = (state == S_SCAN) && (issue < used_count);

  // lookup needs the selected half valid; map and set stop at the first tag match
  logic half_ok;
  logic cmp_match;
  logic scan_hit;
  logic scan_miss;
  assign half_ok   = req_half ? rd_data.valid[1] : rd_data.valid[0];
  assign cmp_match = (rd_data.tag == req_tag) &&
                     ((req_func != ppte_pkg::FUNC_LOOKUP) || half_ok);
  assign scan_hit  = (state == S_SCAN) && pend && cmp_match;
  assign scan_miss = (state == S_SCAN) && pend && !cmp_match && (issue == used_count);

  // output register free for a new result
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // result and update, evaluated in the finish cycle
  logic [1:0]       bit_sel;
  logic             hit_half_valid;
  logic [1:0]       wr_bits;
  logic [1:0]       res_status;
  logic [31:0]      res_base;
  logic             res_append;
  logic [CNT_W-1:0] used_count_next;

  always_comb begin
    bit_sel        = req_half ? 2'b10 : 2'b01;
    hit_half_valid = |(hit_entry.valid & bit_sel);
    wr_bits        = (hit_entry.writable & ~bit_sel) | (req_we ? bit_sel : 2'b00);
    res_status     = ppte_pkg::ST_OK;
    res_base       = '0;
    res_append     = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = hit_idx;
    wr_data        = hit_entry;
    case (req_func)
      ppte_pkg::FUNC_MAP: begin
        if (hit) begin
          if (hit_half_valid) begin
            res_status = ppte_pkg::ST_REMAP;
          end else begin
            wr_en = 1'b1;
            if (req_half) begin
              wr_data.odd_frame = req_frame;
            end else begin
              wr_data.even_frame = req_frame;
            end
            wr_data.valid    = hit_entry.valid | bit_sel;
            wr_data.writable = wr_bits;
          end
        end else if (used_count >= CNT_W'(TABLE_ENTRIES)) begin
          res_status = ppte_pkg::ST_FULL;
        end else begin
          // new entry appended at the fill point, other half cleared
          wr_en              = 1'b1;
          res_append         = 1'b1;
          wr_addr            = used_count[IDX_W-1:0];
          wr_data.space_id   = asid;
          wr_data.tag        = req_tag;
          wr_data.even_frame = req_half ? '0 : req_frame;
          wr_data.odd_frame  = req_half ? req_frame : '0;
          wr_data.valid      = bit_sel;
          wr_data.writable   = req_we ? bit_sel : 2'b00;
        end
      end
      ppte_pkg::FUNC_LOOKUP: begin
        if (hit) begin
          res_base = {(req_half ? hit_entry.odd_frame : hit_entry.even_frame),
                      {ppte_pkg::PAGE_SHIFT{1'b0}}};
        end else begin
          res_status = ppte_pkg::ST_UNMAPPED;
        end
      end
      ppte_pkg::FUNC_SET: begin
        if (hit && hit_half_valid) begin
          wr_en            = 1'b1;
          wr_data.writable = wr_bits;
        end else begin
          res_status = ppte_pkg::ST_UNMAPPED;
        end
      end
      default: begin
        // unused code: no change, plain ok
      end
    endcase
    // only commit when the result can be stored
    if ((state != S_FINISH) || !out_free) begin
      wr_en      = 1'b0;
      res_append = 1'b0;
    end
    used_count_next = used_count + CNT_W'(res_append);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      issue      <= '0;
      pend       <= 1'b0;
      hit        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      used_count <= used_count_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            issue <= '0;
            pend  <= 1'b0;
            hit   <= 1'b0;
            // nothing to search for an empty table or an unused code
            if ((used_count == '0) || !(func inside {ppte_pkg::FUNC_MAP,
                ppte_pkg::FUNC_LOOKUP, ppte_pkg::FUNC_SET})) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend <= rd_en;
          if (rd_en) begin
            issue <= issue + CNT_W'(1);
          end
          if (scan_hit) begin
            hit   <= 1'b1;
            state <= S_FINISH;
          end else if (scan_miss) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= func;
      req_tag   <= virt_addr[31:ppte_pkg::TAG_LSB];
      req_half  <= virt_addr[ppte_pkg::PAGE_SHIFT];
      req_frame <= phys_addr[31:ppte_pkg::PAGE_SHIFT];
      req_we    <= write_enable;
    end
    if (rd_en) begin
      cmp_idx <= issue[IDX_W-1:0];
    end
    if (scan_hit) begin
      hit_entry <= rd_data;
      hit_idx   <= cmp_idx;
    end
    if (state == S_FINISH && out_free) begin
      status       <= res_status;
      page_base    <= res_base;
      entries_used <= 7'(used_count_next);
    end
  end

endmodule
`default_nettype wire

// File: bench/paired_page_table_engine_unit_test.sv
// self-checking testbench of the paired page table engine: directed and random requests, scoreboard
module paired_page_table_engine_unit_test;

  localparam int ENTRIES = ppte_pkg::TABLE_ENTRIES_DEF;
  // func code with no operation behind it
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  // chance in a hundred that a side idles
  localparam int IDLE_PCT = 38;
  // long receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 400;
  // worst request is a full 64 entry scan, and this wait covers one such request
  localparam int DRAIN_CYCLES = 80;
  // cycles with no handshake at all before the run is called hung
  localparam int QUIET_LIMIT = 5000;
  localparam int POOL_SIZE = 96;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] base;
    logic [6:0]  used;
  } reply_t;

  // shadow table plus the queue of replies still owed by the block
  class page_table_book;
    ppte_pkg::entry_t            slots [ENTRIES];
    int unsigned                 used;
    logic [ppte_pkg::ASID_W-1:0] space_id;
    reply_t                      awaited [$];
    int                          failures;
    int                          reported;
    int                          replies_checked;
    int                          status_count [4];

    function new();
      used = 0;
      space_id = '0;
      failures = 0;
      reported = 0;
      replies_checked = 0;
      foreach (slots[i]) slots[i] = '0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_space_id(logic [ppte_pkg::ASID_W-1:0] id);
      space_id = id;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // apply one accepted request to the shadow table and queue the reply it owes
    function void note_request(logic [1:0] op, logic [31:0] va, logic [31:0] pa, logic we);
      logic [ppte_pkg::TAG_W-1:0]   tag;
      logic [ppte_pkg::FRAME_W-1:0] frame;
      logic [1:0]                   sel;
      int                           hit;
      reply_t                       r;
      tag = va[31:ppte_pkg::TAG_LSB];
      frame = pa[31:ppte_pkg::PAGE_SHIFT];
      sel = va[ppte_pkg::PAGE_SHIFT] ? 2'b10 : 2'b01;
      r = '0;
      r.status = ppte_pkg::ST_OK;
      // first entry with a matching tag, whatever its halves hold
      hit = -1;
      for (int i = 0; i < used; i++) begin
        if (slots[i].tag == tag) begin
          hit = i;
          break;
        end
      end
      case (op)
        ppte_pkg::FUNC_MAP: begin
          if (hit >= 0) begin
            if ((slots[hit].valid & sel) != 2'b00) begin
              r.status = ppte_pkg::ST_REMAP;
            end else begin
              if (sel[1]) slots[hit].odd_frame = frame;
              else slots[hit].even_frame = frame;
              slots[hit].valid = slots[hit].valid | sel;
              slots[hit].writable = (slots[hit].writable & ~sel) | (we ? sel : 2'b00);
            end
          end else if (used >= ENTRIES) begin
            r.status = ppte_pkg::ST_FULL;
          end else begin
            // new entry, the other half cleared
            slots[used] = '0;
            slots[used].tag = tag;
            slots[used].space_id = space_id;
            if (sel[1]) slots[used].odd_frame = frame;
            else slots[used].even_frame = frame;
            slots[used].valid = sel;
            slots[used].writable = we ? sel : 2'b00;
            used++;
          end
        end
        ppte_pkg::FUNC_LOOKUP: begin
          // needs the selected half valid, never falls over to the other half
          r.status = ppte_pkg::ST_UNMAPPED;
          for (int i = 0; i < used; i++) begin
            if (slots[i].tag == tag && (slots[i].valid & sel) != 2'b00) begin
              r.status = ppte_pkg::ST_OK;
              r.base = {sel[1] ? slots[i].odd_frame : slots[i].even_frame, 12'h000};
              break;
            end
          end
        end
        ppte_pkg::FUNC_SET: begin
          if (hit < 0 || (slots[hit].valid & sel) == 2'b00) begin
            r.status = ppte_pkg::ST_UNMAPPED;
          end else begin
            slots[hit].writable = (slots[hit].writable & ~sel) | (we ? sel : 2'b00);
          end
        end
        default: ;
      endcase
      r.used = 7'(used);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] base, logic [6:0] used_now);
      reply_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (reported < REPORT_MAX)
          $display("unexpected result: status %0d page_base %h entries_used %0d",
                   st, base, used_now);
        reported++;
        return;
      end
      want = awaited.pop_front();
      replies_checked++;
      status_count[want.status]++;
      if (st !== want.status || base !== want.base || used_now !== want.used) begin
        failures++;
        if (reported < REPORT_MAX)
          $display("mismatch: status %0d/%0d page_base %h/%h entries_used %0d/%0d (exp/got)",
                   want.status, st, want.base, base, want.used, used_now);
        reported++;
      end
    endfunction

    // anything still owed at the end counts against the run
    function void close();
      if (awaited.size() != 0) begin
        failures += awaited.size();
        $display("%0d results never arrived", awaited.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic        write_enable;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] page_base;
  logic [6:0]  entries_used;

  page_table_book             book;
  logic [ppte_pkg::TAG_W-1:0] tag_pool [POOL_SIZE];
  // set by the stimulus only: no random idling on either side while high (a long hold-off still wins)
  bit                         calm;
  // the stimulus bumps hold_asks, the receiver answers with one long hold-off
  int                         hold_asks;
  int                         hold_seen;
  int                         hold_left;
  int                         requests_taken;
  int                         space_id_writes;
  int                         quiet_cycles;

  paired_page_table_engine_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .virt_addr    (virt_addr),
    .phys_addr    (phys_addr),
    .write_enable (write_enable),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .page_base    (page_base),
    .entries_used (entries_used)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side: random stalls, a calm stretch, and one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // both handshakes are sampled at the edge; results checked before new requests noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) book.check_result(status, page_base, entries_used);
      if (in_valid && !in_stall) begin
        book.note_request(func, virt_addr, phys_addr, write_enable);
        requests_taken++;
      end
    end
  end

  // hang detector: any handshake restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request and hold it until the block takes it
  task automatic send_request(logic [1:0] op, logic [31:0] va, logic [31:0] pa, logic we);
    in_valid <= 1'b1;
    func <= op;
    virt_addr <= va;
    phys_addr <= pa;
    write_enable <= we;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue(logic [1:0] op, logic [31:0] va, logic [31:0] pa, logic we);
    send_request(op, va, pa, we);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // sender pauses until every owed result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  // register writes only on an idle block
  task automatic write_space_id(logic [7:0] id);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= id;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.set_space_id(id);
    space_id_writes++;
  endtask

  // mostly addresses from a tag pool so entries get hit again, some fully random
  task automatic random_item(int map_pct, int look_pct, int set_pct);
    int          roll;
    logic [1:0]  op;
    logic [31:0] va;
    roll = $urandom_range(99);
    if (roll < map_pct) op = ppte_pkg::FUNC_MAP;
    else if (roll < map_pct + look_pct) op = ppte_pkg::FUNC_LOOKUP;
    else if (roll < map_pct + look_pct + set_pct) op = ppte_pkg::FUNC_SET;
    else op = FUNC_SPARE;
    if ($urandom_range(9) == 0) va = $urandom();
    else va = {tag_pool[$urandom_range(POOL_SIZE - 1)], 13'($urandom())};
    issue(op, va, $urandom(), 1'($urandom()));
  endtask

  initial begin
    book = new();
    rst = 1'b1;
    calm = 1'b0;
    hold_asks = 0;
    requests_taken = 0;
    space_id_writes = 0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = ppte_pkg::FUNC_MAP;
    virt_addr = '0;
    phys_addr = '0;
    write_enable = 1'b0;
    foreach (tag_pool[i]) tag_pool[i] = ppte_pkg::TAG_W'($urandom());
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_space_id(8'hFF);

    // directed: empty table, both halves, address extremes, spare func
    issue(ppte_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);  // miss on empty table
    issue(ppte_pkg::FUNC_SET,    32'h0000_0000, 32'h0000_0000, 1'b1);  // set on unmapped page
    issue(FUNC_SPARE,            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // spare func, no change
    issue(ppte_pkg::FUNC_MAP,    32'h0000_0000, 32'hFFFF_F123, 1'b1);  // new entry, even half
    issue(ppte_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
    issue(ppte_pkg::FUNC_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b0);  // odd half still empty
    issue(ppte_pkg::FUNC_MAP,    32'h0000_0FFF, 32'h1234_5000, 1'b0);  // remap of even half
    issue(ppte_pkg::FUNC_SET,    32'h0000_1000, 32'h0000_0000, 1'b1);  // tag hit, half invalid
    issue(ppte_pkg::FUNC_MAP,    32'h0000_1000, 32'h0000_0000, 1'b0);  // fill the odd half
    issue(ppte_pkg::FUNC_LOOKUP, 32'h0000_1FFF, 32'hFFFF_FFFF, 1'b1);  // frame zero hit
    issue(ppte_pkg::FUNC_SET,    32'h0000_0000, 32'h0000_0000, 1'b0);
    issue(ppte_pkg::FUNC_MAP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // new entry, odd half
    issue(ppte_pkg::FUNC_LOOKUP, 32'hFFFF_EFFF, 32'h0000_0000, 1'b0);  // even never to odd
    issue(ppte_pkg::FUNC_LOOKUP, 32'hFFFF_F000, 32'h0000_0000, 1'b0);
    issue(ppte_pkg::FUNC_SET,    32'hFFFF_E000, 32'h0000_0000, 1'b1);  // cleared half
    issue(ppte_pkg::FUNC_SET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    issue(ppte_pkg::FUNC_MAP,    32'hFFFF_E000, 32'h1234_5678, 1'b0);
    issue(ppte_pkg::FUNC_LOOKUP, 32'hFFFF_EABC, 32'h0000_0000, 1'b0);
    issue(FUNC_SPARE,            32'h0000_0000, 32'h0000_0000, 1'b0);
    issue(ppte_pkg::FUNC_MAP,    32'hAAAA_A5A5, 32'h5555_5A5A, 1'b1);
    issue(ppte_pkg::FUNC_MAP,    32'h5555_5A5A, 32'hAAAA_A5A5, 1'b0);
    issue(ppte_pkg::FUNC_LOOKUP, 32'hAAAA_A000, 32'h0000_0000, 1'b0);
    issue(ppte_pkg::FUNC_LOOKUP, 32'h5555_4000, 32'h0000_0000, 1'b0);  // other half

    write_space_id(8'h00);

    // map heavy, so the table fills and full errors follow
    for (int i = 0; i < 200; i++) random_item(70, 15, 10);

    write_space_id(8'($urandom()));

    // receiver holds off while the sender keeps offering
    hold_asks++;
    for (int i = 0; i < 200; i++) begin
      if (i == 60) calm = 1'b1;
      if (i == 140) calm = 1'b0;
      if (i == 150) wait_drained();
      random_item(30, 40, 25);
    end

    write_space_id(8'h80);

    for (int i = 0; i < 150; i++) random_item(35, 35, 25);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    book.close();

    $display("covered %0d requests, %0d results checked, %0d space id writes, %0d/%0d entries",
             requests_taken, book.replies_checked, space_id_writes, book.used, ENTRIES);
    $display("result mix: ok %0d, remap %0d, full %0d, unmapped %0d",
             book.status_count[ppte_pkg::ST_OK], book.status_count[ppte_pkg::ST_REMAP],
             book.status_count[ppte_pkg::ST_FULL], book.status_count[ppte_pkg::ST_UNMAPPED]);
    if (book.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", book.failures);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
